// File: hdl/swcb_pkg.sv
// Package: constants, types and command codes of the send-window command buffer
package swcb_pkg;
   localparam int Capacity = 32;
   localparam int PayloadBits = 64;
   localparam int MaxResults = 32;
   localparam int AddrBits = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CountBits = $clog2(Capacity + 1);
   localparam int EntryBits = 32 + 32 + PayloadBits;

   typedef logic [AddrBits-1:0] addr_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [PayloadBits-1:0] payload_type;
   typedef logic [EntryBits-1:0] entry_type;

   typedef enum logic [2:0] {
      CMD_PUSH = 3'd0,
      CMD_MARK_SENT = 3'd1,
      CMD_ACK = 3'd2,
      CMD_FIND = 3'd3,
      CMD_READ_PEND = 3'd4,
      CMD_READ_UNACK = 3'd5,
      CMD_CLEAR = 3'd6,
      CMD_NONE = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE,
      ST_ACK_U,
      ST_ACK_P,
      ST_FIND_U,
      ST_FIND_P,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [31:0] new_sequence;
      logic [31:0] new_tick;
      logic [63:0] new_payload;
      logic [31:0] sent_limit;
      logic [31:0] ack_limit;
      logic [31:0] search_tick;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic found;
      logic entry_valid;
      logic [31:0] entry_sequence;
      logic [31:0] entry_tick;
      logic [63:0] entry_payload;
      logic last;
      logic [5:0] pending_count;
      logic [5:0] unacked_count;
      logic full_res;
   } rsp_type;

   function automatic addr_type slot_next(addr_type a);
      logic [AddrBits:0] s;
      s = {1'b0, a} + 1'b1;
      if (s >= (AddrBits+1)'(Capacity)) s = '0;
      return s[AddrBits-1:0];
   endfunction

   function automatic addr_type slot_add(addr_type h, count_type n);
      logic [CountBits+AddrBits:0] s;
      s = (CountBits+AddrBits+1)'(h) + (CountBits+AddrBits+1)'(n);
      if (s >= (CountBits+AddrBits+1)'(Capacity)) s = s - (CountBits+AddrBits+1)'(Capacity);
      return s[AddrBits-1:0];
   endfunction
endpackage

// File: hdl/swcb_if.sv
// Interfaces: valid/ready channels for request and response transactions
interface swcb_req_if (input logic clock);
   import swcb_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface swcb_rsp_if (input logic clock);
   import swcb_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hdl/swcb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module swcb_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/send_window_command_buffer.sv
// Top level: two FIFO command queues (pending, unacked) held in RAM
// Usage:
//   req channel carries one command transaction (push, mark sent, ack, find,
//   read pending, read unacked, clear); rsp channel returns its results, the
//   final one flagged by last. Reads give one transaction per stored entry, or one if empty.
//   Each queue sits in one RAM with a registered read; head and size
//   counters live in flops.
// Operation:
//   push, clear: result registered from ST_RESP after acceptance.
//   mark sent moves pending head entries within sent_limit to unacked;
//   ack drops unacked, then pending head entries within ack_limit; each
//   head read waits for the registered RAM data before the compare.
//   find examines unacked entries, then pending ones, and stops at a match.
//   read returns stored entries from the head, up to MaxResults of them.
//   One command is in progress at a time; req ready is low until its last
//   result has been taken.
// Reset: synchronous; both queues empty. RAM contents are not cleared.
// Stall: while rsp ready is low the held result stays put and the walk
//   through the RAM pauses.
module send_window_command_buffer (
   input logic clock,
   input logic reset,
   swcb_req_if.sink req,
   swcb_rsp_if.source rsp
);
   import swcb_pkg::*;

   state_type state_ff, state_in;
   req_type cmd_ff, cmd_in;
   addr_type p_head_ff, p_head_in, u_head_ff, u_head_in;
   count_type p_size_ff, p_size_in, u_size_ff, u_size_in;
   count_type idx_ff, idx_in;      // entries walked
   logic rd_wait_ff, rd_wait_in;   // RAM data not yet valid for current address
   logic acc_ff, acc_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic p_we, u_we;
   addr_type p_wa, u_wa, p_ra, u_ra;
   entry_type p_wd, u_wd, p_rd, u_rd;

   swcb_ram #(.Width(EntryBits), .Depth(Capacity)) u_pend_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   swcb_ram #(.Width(EntryBits), .Depth(Capacity)) u_unack_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
      .rd_addr(u_ra), .rd_data(u_rd));

   logic [31:0] p_seq, u_seq, p_tick, u_tick;
   logic full_now;
   count_type walk_n;
   entry_type sel_rd;

   assign p_seq = p_rd[EntryBits-1 -: 32];
   assign u_seq = u_rd[EntryBits-1 -: 32];
   assign p_tick = p_rd[PayloadBits +: 32];
   assign u_tick = u_rd[PayloadBits +: 32];
   assign full_now = ((CountBits+1)'(p_size_ff) + (CountBits+1)'(u_size_ff))
                     >= (CountBits+1)'(Capacity);
   assign sel_rd = (cmd_ff.cmd == CMD_READ_PEND) ? p_rd : u_rd;

   always_comb begin
      count_type n;
      n = (cmd_ff.cmd == CMD_READ_PEND) ? p_size_ff : u_size_ff;
      if ((CountBits+1)'(n) > (CountBits+1)'(MaxResults)) n = CountBits'(MaxResults);
      walk_n = n;
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               case (cmd_type'(req.data.cmd))
                  CMD_MARK_SENT: state_in = ST_MOVE;
                  CMD_ACK: state_in = ST_ACK_U;
                  CMD_FIND: state_in = ST_FIND_U;
                  CMD_READ_PEND, CMD_READ_UNACK: state_in = ST_READ;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_MOVE: begin
            if (!rd_wait_ff && !(p_size_ff != '0 &&
                (CountBits+1)'(u_size_ff) < (CountBits+1)'(Capacity) &&
                p_seq <= cmd_ff.sent_limit)) state_in = ST_RESP;
         end
         ST_ACK_U: begin
            if (!rd_wait_ff && !(u_size_ff != '0 && u_seq <= cmd_ff.ack_limit))
               state_in = ST_ACK_P;
         end
         ST_ACK_P: begin
            if (!rd_wait_ff && !(p_size_ff != '0 && p_seq <= cmd_ff.ack_limit))
               state_in = ST_RESP;
         end
         ST_FIND_U: begin
            if (!rd_wait_ff) begin
               if (idx_ff < u_size_ff && u_tick == cmd_ff.search_tick) state_in = ST_RESP;
               else if (idx_ff >= u_size_ff) state_in = ST_FIND_P;
            end
         end
         ST_FIND_P: begin
            if (!rd_wait_ff) begin
               if (idx_ff >= p_size_ff || p_tick == cmd_ff.search_tick) state_in = ST_RESP;
            end
         end
         ST_READ: begin
            if (!rd_wait_ff && (walk_n == '0 ||
                ((CountBits+1)'(idx_ff) + 1'b1 >= (CountBits+1)'(walk_n) &&
                 (!rsp_valid_ff || rsp.ready)))) state_in = ST_IDLE;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rsp_type r;
      cmd_in = cmd_ff;
      p_head_in = p_head_ff;
      u_head_in = u_head_ff;
      p_size_in = p_size_ff;
      u_size_in = u_size_ff;
      idx_in = idx_ff;
      rd_wait_in = 1'b0;
      acc_in = acc_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      p_we = 1'b0;
      u_we = 1'b0;
      p_wa = slot_add(p_head_ff, p_size_ff);
      u_wa = slot_add(u_head_ff, u_size_ff);
      p_wd = {cmd_ff.new_sequence, cmd_ff.new_tick, cmd_ff.new_payload[PayloadBits-1:0]};
      u_wd = p_rd;
      p_ra = p_head_ff;
      u_ra = u_head_ff;
      r = '0;
      r.last = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.data;
               idx_in = '0;
               acc_in = 1'b0;
               rd_wait_in = 1'b1;
               if (cmd_type'(req.data.cmd) == CMD_PUSH && !full_now) begin
                  p_we = 1'b1;
                  p_wd = {req.data.new_sequence, req.data.new_tick,
                          req.data.new_payload[PayloadBits-1:0]};
                  p_size_in = p_size_ff + 1'b1;
                  acc_in = 1'b1;
               end
               if (cmd_type'(req.data.cmd) == CMD_CLEAR) begin
                  p_head_in = '0; u_head_in = '0; p_size_in = '0; u_size_in = '0;
               end
               if (cmd_type'(req.data.cmd) == CMD_READ_PEND ||
                   cmd_type'(req.data.cmd) == CMD_READ_UNACK) begin
                  p_ra = p_head_ff;
                  u_ra = u_head_ff;
               end
            end
         end
         ST_MOVE: begin
            if (!rd_wait_ff && p_size_ff != '0 &&
                (CountBits+1)'(u_size_ff) < (CountBits+1)'(Capacity) &&
                p_seq <= cmd_ff.sent_limit) begin
               u_we = 1'b1;
               u_size_in = u_size_ff + 1'b1;
               p_size_in = p_size_ff - 1'b1;
               p_head_in = slot_next(p_head_ff);
               rd_wait_in = 1'b1;
            end
         end
         ST_ACK_U: begin
            if (!rd_wait_ff) begin
               rd_wait_in = 1'b1;
               if (u_size_ff != '0 && u_seq <= cmd_ff.ack_limit) begin
                  u_size_in = u_size_ff - 1'b1;
                  u_head_in = slot_next(u_head_ff);
               end
            end
         end
         ST_ACK_P: begin
            if (!rd_wait_ff && p_size_ff != '0 && p_seq <= cmd_ff.ack_limit) begin
               p_size_in = p_size_ff - 1'b1;
               p_head_in = slot_next(p_head_ff);
               rd_wait_in = 1'b1;
            end
         end
         ST_FIND_U: begin
            u_ra = slot_add(u_head_ff, idx_ff);
            if (!rd_wait_ff) begin
               if (idx_ff < u_size_ff && u_tick == cmd_ff.search_tick) begin
                  r.found = 1'b1; r.entry_valid = 1'b1;
                  {r.entry_sequence, r.entry_tick} = u_rd[EntryBits-1 -: 64];
                  r.entry_payload = 64'(u_rd[PayloadBits-1:0]);
                  rsp_in = r;
               end else if (idx_ff >= u_size_ff) begin
                  idx_in = '0;
                  p_ra = p_head_ff;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  u_ra = slot_add(u_head_ff, idx_ff + 1'b1);
               end
               rd_wait_in = 1'b0;
            end
         end
         ST_FIND_P: begin
            p_ra = slot_add(p_head_ff, idx_ff);
            if (!rd_wait_ff) begin
               if (idx_ff < p_size_ff && p_tick == cmd_ff.search_tick) begin
                  r.found = 1'b1; r.entry_valid = 1'b1;
                  {r.entry_sequence, r.entry_tick} = p_rd[EntryBits-1 -: 64];
                  r.entry_payload = 64'(p_rd[PayloadBits-1:0]);
                  rsp_in = r;
               end else if (idx_ff < p_size_ff) begin
                  idx_in = idx_ff + 1'b1;
                  p_ra = slot_add(p_head_ff, idx_ff + 1'b1);
               end else begin
                  rsp_in = r;
               end
            end
         end
         ST_READ: begin
            p_ra = slot_add(p_head_ff, idx_ff);
            u_ra = slot_add(u_head_ff, idx_ff);
            if (!rd_wait_ff) begin
               if (walk_n == '0) begin
                  r.pending_count = 6'(p_size_ff);
                  r.unacked_count = 6'(u_size_ff);
                  r.full_res = full_now;
                  rsp_in = r;
                  rsp_valid_in = 1'b1;
               end else if (!rsp_valid_ff || rsp.ready) begin
                  r.entry_valid = 1'b1;
                  {r.entry_sequence, r.entry_tick} = sel_rd[EntryBits-1 -: 64];
                  r.entry_payload = 64'(sel_rd[PayloadBits-1:0]);
                  r.last = (CountBits+1)'(idx_ff) + 1'b1 >= (CountBits+1)'(walk_n);
                  r.pending_count = 6'(p_size_ff);
                  r.unacked_count = 6'(u_size_ff);
                  r.full_res = full_now;
                  rsp_in = r;
                  rsp_valid_in = 1'b1;
                  idx_in = idx_ff + 1'b1;
                  p_ra = slot_add(p_head_ff, idx_ff + 1'b1);
                  u_ra = slot_add(u_head_ff, idx_ff + 1'b1);
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               if (cmd_ff.cmd != CMD_FIND) rsp_in = r;
               rsp_in.accepted = acc_ff;
               rsp_in.pending_count = 6'(p_size_ff);
               rsp_in.unacked_count = 6'(u_size_ff);
               rsp_in.full_res = full_now;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p_head_ff <= '0;
         u_head_ff <= '0;
         p_size_ff <= '0;
         u_size_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_wait_ff <= 1'b0;
         idx_ff <= '0;
         acc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_head_ff <= p_head_in;
         u_head_ff <= u_head_in;
         p_size_ff <= p_size_in;
         u_size_ff <= u_size_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_wait_ff <= rd_wait_in;
         idx_ff <= idx_in;
         acc_ff <= acc_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end
endmodule

// File: dv/swcb_tb_if.sv
// Interface check: the testbench uses the RTL interfaces from hdl; nothing else is declared here
`timescale 1ns / 1ps

// File: dv/tb_send_window_command_buffer.sv
// Testbench: directed and random command sequences checked against an internal queue model
`timescale 1ns / 1ps
module tb_send_window_command_buffer;
   import swcb_pkg::*;

   logic clock;
   logic reset;
   int errors;

   swcb_req_if req (clock);
   swcb_rsp_if rsp (clock);

   send_window_command_buffer i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   typedef struct {
      logic [31:0] sq;
      logic [31:0] tk;
      logic [63:0] pl;
   } cmd_entry_type;

   cmd_entry_type pend_q[$];
   cmd_entry_type unack_q[$];
   rsp_type expected_rsp[$];
   int seq_base;

   function automatic void queue_result(rsp_type r);
      expected_rsp.insert(expected_rsp.size(), r);
   endfunction

   function automatic rsp_type status_rsp();
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      r.pending_count = 6'(pend_q.size());
      r.unacked_count = 6'(unack_q.size());
      r.full_res = (pend_q.size() + unack_q.size() >= Capacity);
      return r;
   endfunction

   function automatic rsp_type entry_rsp(cmd_entry_type e, logic lst);
      rsp_type r;
      r = status_rsp();
      r.entry_valid = 1'b1;
      r.entry_sequence = e.sq;
      r.entry_tick = e.tk;
      r.entry_payload = e.pl;
      r.last = lst;
      return r;
   endfunction

   // Update the queue model and queue the results this command causes
   task automatic predict_window(req_type c);
      rsp_type r;
      cmd_entry_type e;
      int n;
      bit hit;
      hit = 0;
      case (cmd_type'(c.cmd))
         CMD_PUSH: begin
            if (pend_q.size() + unack_q.size() >= Capacity) begin
               queue_result(status_rsp());
            end else begin
               e.sq = c.new_sequence;
               e.tk = c.new_tick;
               e.pl = c.new_payload;
               pend_q.insert(pend_q.size(), e);
               r = status_rsp();
               r.accepted = 1'b1;
               queue_result(r);
            end
         end
         CMD_MARK_SENT: begin
            while (pend_q.size() > 0 && unack_q.size() < Capacity &&
                   pend_q[0].sq <= c.sent_limit) begin
               e = pend_q[0];
               pend_q.delete(0);
               unack_q.insert(unack_q.size(), e);
            end
            queue_result(status_rsp());
         end
         CMD_ACK: begin
            while (unack_q.size() > 0 && unack_q[0].sq <= c.ack_limit)
               unack_q.delete(0);
            while (pend_q.size() > 0 && pend_q[0].sq <= c.ack_limit)
               pend_q.delete(0);
            queue_result(status_rsp());
         end
         CMD_FIND: begin
            foreach (unack_q[i])
               if (!hit && unack_q[i].tk == c.search_tick) begin
                  r = entry_rsp(unack_q[i], 1'b1);
                  hit = 1;
               end
            foreach (pend_q[i])
               if (!hit && pend_q[i].tk == c.search_tick) begin
                  r = entry_rsp(pend_q[i], 1'b1);
                  hit = 1;
               end
            if (hit) r.found = 1'b1;
            else r = status_rsp();
            queue_result(r);
         end
         CMD_READ_PEND, CMD_READ_UNACK: begin
            n = (c.cmd == CMD_READ_PEND) ? pend_q.size() : unack_q.size();
            if (n > MaxResults) n = MaxResults;
            if (n == 0) queue_result(status_rsp());
            for (int k = 0; k < n; k++)
               queue_result(entry_rsp((c.cmd == CMD_READ_PEND) ?
                  pend_q[k] : unack_q[k], k == n - 1));
         end
         CMD_CLEAR: begin
            pend_q.delete();
            unack_q.delete();
            queue_result(status_rsp());
         end
         default: queue_result(status_rsp());
      endcase
   endtask

   function automatic req_type rand_bits();
      return {3'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
   endfunction

   // Send one request transaction after a random gap; returns at a falling edge
   task automatic send_cmd(req_type c);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         req.data <= rand_bits();
         repeat (gap) @(negedge clock);
      end
      req.data <= c;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      predict_window(c);
      @(negedge clock);
   endtask

   function automatic req_type rand_req(cmd_type op);
      req_type c;
      c = rand_bits();
      c.cmd = op;
      return c;
   endfunction

   // Near-monotone sequences so mark sent and ack act on prefixes
   function automatic req_type push_req();
      req_type c;
      c = rand_req(CMD_PUSH);
      seq_base += $urandom_range(0, 3);
      c.new_sequence = seq_base;
      c.new_tick = $urandom_range(0, 40);
      return c;
   endfunction

   function automatic req_type limit_req(cmd_type op);
      req_type c;
      int lim;
      c = rand_req(op);
      lim = seq_base - $urandom_range(0, 20);
      c.sent_limit = lim;
      c.ack_limit = lim;
      c.search_tick = $urandom_range(0, 45);
      return c;
   endfunction

   // Result checker with random back-pressure
   initial begin
      int stall;
      rsp_type exp_r;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!(rsp.valid && rsp.ready) || reset);
         if (expected_rsp.size() == 0) begin
            $display("%0t unexpected result: expected none actual %p", $time, rsp.data);
            errors++;
         end else begin
            exp_r = expected_rsp[0];
            expected_rsp.delete(0);
            if (rsp.data !== exp_r) begin
               $display("%0t mismatch: expected %p actual %p", $time, exp_r, rsp.data);
               errors++;
            end
         end
      end
   end

   task automatic test_extremes();
      req_type c;
      send_cmd(rand_req(CMD_READ_PEND));
      send_cmd(rand_req(CMD_READ_UNACK));
      send_cmd(rand_req(CMD_FIND));
      c = rand_req(CMD_PUSH);
      c.new_sequence = '0; c.new_tick = '0; c.new_payload = '0;
      send_cmd(c);
      c = rand_req(CMD_PUSH);
      c.new_sequence = '1; c.new_tick = '1; c.new_payload = '1;
      send_cmd(c);
      c = rand_req(CMD_FIND); c.search_tick = '1;
      send_cmd(c);
      c = rand_req(CMD_MARK_SENT); c.sent_limit = '0;
      send_cmd(c);
      send_cmd(rand_req(CMD_READ_UNACK));
      c = rand_req(CMD_MARK_SENT); c.sent_limit = '1;
      send_cmd(c);
      c = rand_req(CMD_FIND); c.search_tick = '0;
      send_cmd(c);
      c = rand_req(CMD_ACK); c.ack_limit = '1;
      send_cmd(c);
      send_cmd(rand_req(CMD_NONE));
   endtask

   task automatic test_full();
      req_type c;
      for (int i = 0; i < Capacity + 2; i++) begin
         c = rand_req(CMD_PUSH);
         c.new_sequence = i;
         send_cmd(c);
      end
      c = rand_req(CMD_MARK_SENT); c.sent_limit = 9;
      send_cmd(c);
      send_cmd(rand_req(CMD_READ_PEND));
      send_cmd(rand_req(CMD_READ_UNACK));
      c = rand_req(CMD_ACK); c.ack_limit = 4;
      send_cmd(c);
      send_cmd(rand_req(CMD_CLEAR));
      send_cmd(rand_req(CMD_READ_PEND));
   endtask

   task automatic test_random();
      int pick;
      for (int i = 0; i < 170; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) send_cmd(push_req());
         else if (pick < 58) send_cmd(limit_req(CMD_MARK_SENT));
         else if (pick < 68) send_cmd(limit_req(CMD_ACK));
         else if (pick < 80) send_cmd(limit_req(CMD_FIND));
         else if (pick < 87) send_cmd(rand_req(CMD_READ_PEND));
         else if (pick < 94) send_cmd(rand_req(CMD_READ_UNACK));
         else if (pick < 97) send_cmd(rand_req(CMD_CLEAR));
         else if (pick < 98) send_cmd(rand_req(CMD_NONE));
         else send_cmd(rand_req(cmd_type'(3'($urandom_range(0, 7)))));
      end
   endtask

   initial begin
      #10000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      errors = 0;
      seq_base = 100;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_full();
      test_random();
      req.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
